// ===== sv/dbd_pkg.sv =====
// Shared types, widths and constants for the detection box decoder.
`default_nettype none

package dbd_pkg;

    // Class scores per box; the class index saturates at MAX_CLASSES-1.
    localparam int MAX_CLASSES = 256;
    localparam int CLASS_W     = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;

    localparam int SCORE_W  = 16;
    localparam int COORD_W  = 14;   // center / size, 1/16 network pixel
    localparam int PAD_W    = 10;
    localparam int SCALE_W  = 24;   // Q8.16
    localparam int IMG_W    = 13;
    localparam int EDGE_LO_W = 13;  // left / top
    localparam int EDGE_HI_W = 14;  // right / bottom, signed
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    // Corner arithmetic in 1/32 network pixel units.
    localparam int PAD_SHIFT   = 5;
    localparam int NUM_W       = 18;                  // signed numerator
    localparam int MAG_W       = NUM_W - 1;
    localparam int PROD_W      = MAG_W + SCALE_W;
    localparam int SCALE_SHIFT = 21;
    localparam int QMAG_W      = PROD_W - SCALE_SHIFT;
    localparam int Q_W         = QMAG_W + 2;          // signed corner in pixels

    localparam logic [SCORE_W-1:0] THRESH_RST = 16'd16384;
    localparam logic [SCALE_W-1:0] SCALE_RST  = 24'd65536;
    localparam logic [IMG_W-1:0]   IMG_RST    = 13'd640;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCORE_THRESHOLD = 3'd0,
        REG_X_PADDING       = 3'd1,
        REG_Y_PADDING       = 3'd2,
        REG_INVERSE_SCALE   = 3'd3,
        REG_IMAGE_WIDTH     = 3'd4,
        REG_IMAGE_HEIGHT    = 3'd5
    } cfg_reg_t;

    // Load strobes for the corner datapath stages.
    typedef struct packed {
        logic num_load;
        logic prod_load;
    } stage_ctl_t;

endpackage

`default_nettype wire

// ===== sv/detection_box_decoder.sv =====
// Detection box decoder top level: running arg-max over class scores, box un-letterboxing.
// Throughput: one input transaction per cycle; s_ready drops only when all four detection
// registers hold a detection and m_ready is low.
// A detection reaches m_valid through the corner pipeline stages: operand register,
// offset/abs, 17x24 multiply, clamp/output register.
// Reset (synchronous, aresetn low): empties the pipeline, closes any open box, restores config.
`default_nettype none

module detection_box_decoder (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    // configuration write port
    input  wire logic                                cfg_wr_en,
    input  wire logic [dbd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [dbd_pkg::CFG_DATA_W-1:0]      cfg_wdata,

    // class score stream
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [dbd_pkg::COORD_W-1:0]         s_center_x,
    input  wire logic [dbd_pkg::COORD_W-1:0]         s_center_y,
    input  wire logic [dbd_pkg::COORD_W-1:0]         s_box_width,
    input  wire logic [dbd_pkg::COORD_W-1:0]         s_box_height,
    input  wire logic [dbd_pkg::SCORE_W-1:0]         s_class_score,
    input  wire logic                                s_last_score,

    // detection stream
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [dbd_pkg::CLASS_W-1:0]              m_label,
    output logic [dbd_pkg::SCORE_W-1:0]              m_confidence,
    output logic [dbd_pkg::EDGE_LO_W-1:0]            m_left,
    output logic [dbd_pkg::EDGE_LO_W-1:0]            m_top,
    output logic signed [dbd_pkg::EDGE_HI_W-1:0]     m_right,
    output logic signed [dbd_pkg::EDGE_HI_W-1:0]     m_bottom
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [dbd_pkg::SCORE_W-1:0] thresh_reg;
    logic [dbd_pkg::PAD_W-1:0]   x_pad_reg;
    logic [dbd_pkg::PAD_W-1:0]   y_pad_reg;
    logic [dbd_pkg::SCALE_W-1:0] inv_scale_reg;
    logic [dbd_pkg::IMG_W-1:0]   img_w_reg;
    logic [dbd_pkg::IMG_W-1:0]   img_h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg    <= dbd_pkg::THRESH_RST;
            x_pad_reg     <= '0;
            y_pad_reg     <= '0;
            inv_scale_reg <= dbd_pkg::SCALE_RST;
            img_w_reg     <= dbd_pkg::IMG_RST;
            img_h_reg     <= dbd_pkg::IMG_RST;
        end else if (cfg_wr_en) begin
            // out-of-range index falls through: write dropped
            unique case (cfg_index)
                dbd_pkg::REG_SCORE_THRESHOLD: thresh_reg    <= cfg_wdata[dbd_pkg::SCORE_W-1:0];
                dbd_pkg::REG_X_PADDING:       x_pad_reg     <= cfg_wdata[dbd_pkg::PAD_W-1:0];
                dbd_pkg::REG_Y_PADDING:       y_pad_reg     <= cfg_wdata[dbd_pkg::PAD_W-1:0];
                dbd_pkg::REG_INVERSE_SCALE:   inv_scale_reg <= cfg_wdata[dbd_pkg::SCALE_W-1:0];
                dbd_pkg::REG_IMAGE_WIDTH:     img_w_reg     <= cfg_wdata[dbd_pkg::IMG_W-1:0];
                dbd_pkg::REG_IMAGE_HEIGHT:    img_h_reg     <= cfg_wdata[dbd_pkg::IMG_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: each stage moves when the one after it has
    // room or is itself moving on, so bubbles collapse and the input side
    // keeps going while a detection waits at the output.
    // ------------------------------------------------------------------
    logic p1_valid_reg, p2_valid_reg, p3_valid_reg, m_valid_reg;
    logic out_free, p3_free, p2_free, p1_free;
    logic p1_adv, p2_adv, p3_adv;
    logic in_xact;
    dbd_pkg::stage_ctl_t corner_ctl;

    always_comb begin
        out_free = !m_valid_reg || m_ready;
        p3_adv   = p3_valid_reg && out_free;
        p3_free  = !p3_valid_reg || out_free;
        p2_adv   = p2_valid_reg && p3_free;
        p2_free  = !p2_valid_reg || p3_free;
        p1_adv   = p1_valid_reg && p2_free;
        p1_free  = !p1_valid_reg || p2_free;
        s_ready  = p1_free;
        in_xact  = s_valid && s_ready;
        corner_ctl.num_load  = p1_adv;
        corner_ctl.prod_load = p2_adv;
    end

    // ------------------------------------------------------------------
    // Running arg-max over one box's scores
    // ------------------------------------------------------------------
    logic                        box_open_reg;
    logic [dbd_pkg::SCORE_W-1:0] best_score_reg;
    logic [dbd_pkg::CLASS_W-1:0] best_class_reg;
    logic [dbd_pkg::CLASS_W-1:0] class_cnt_reg;
    logic [dbd_pkg::COORD_W-1:0] held_cx_reg, held_cy_reg, held_w_reg, held_h_reg;

    logic [dbd_pkg::SCORE_W-1:0] cur_best, best_next;
    logic [dbd_pkg::CLASS_W-1:0] cur_class, cur_cnt, class_next, cnt_inc;
    logic [dbd_pkg::COORD_W-1:0] box_cx, box_cy, box_w, box_h;
    logic                        emit;

    always_comb begin
        // first score of a box starts from zero / class 0 and takes the new box
        cur_best  = box_open_reg ? best_score_reg : '0;
        cur_class = box_open_reg ? best_class_reg : '0;
        cur_cnt   = box_open_reg ? class_cnt_reg  : '0;
        box_cx    = box_open_reg ? held_cx_reg : s_center_x;
        box_cy    = box_open_reg ? held_cy_reg : s_center_y;
        box_w     = box_open_reg ? held_w_reg  : s_box_width;
        box_h     = box_open_reg ? held_h_reg  : s_box_height;

        // strictly greater wins, so the lowest class keeps a tie
        if (s_class_score > cur_best) begin
            best_next  = s_class_score;
            class_next = cur_cnt;
        end else begin
            best_next  = cur_best;
            class_next = cur_class;
        end

        // saturate the class index at the last class
        cnt_inc = (cur_cnt == dbd_pkg::CLASS_W'(dbd_pkg::MAX_CLASSES - 1)) ?
                  cur_cnt : cur_cnt + 1'b1;

        emit = s_last_score && (best_next >= thresh_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_open_reg <= 1'b0;
        end else if (in_xact) begin
            box_open_reg <= !s_last_score;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xact) begin
            best_score_reg <= best_next;
            best_class_reg <= class_next;
            class_cnt_reg  <= s_last_score ? '0 : cnt_inc;
            held_cx_reg    <= box_cx;
            held_cy_reg    <= box_cy;
            held_w_reg     <= box_w;
            held_h_reg     <= box_h;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: detection record (passed threshold)
    // ------------------------------------------------------------------
    logic [dbd_pkg::CLASS_W-1:0] p1_class_reg, p2_class_reg, p3_class_reg;
    logic [dbd_pkg::SCORE_W-1:0] p1_score_reg, p2_score_reg, p3_score_reg;
    logic [dbd_pkg::COORD_W-1:0] p1_cx_reg, p1_cy_reg, p1_w_reg, p1_h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (p1_free) begin
                p1_valid_reg <= in_xact && emit;
            end
            if (p2_free) begin
                p2_valid_reg <= p1_adv;
            end
            if (p3_free) begin
                p3_valid_reg <= p2_adv;
            end
            if (out_free) begin
                m_valid_reg <= p3_adv;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xact && emit) begin
            p1_class_reg <= class_next;
            p1_score_reg <= best_next;
            p1_cx_reg    <= box_cx;
            p1_cy_reg    <= box_cy;
            p1_w_reg     <= box_w;
            p1_h_reg     <= box_h;
        end
        if (p1_adv) begin
            p2_class_reg <= p1_class_reg;
            p2_score_reg <= p1_score_reg;
        end
        if (p2_adv) begin
            p3_class_reg <= p2_class_reg;
            p3_score_reg <= p2_score_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stages 2 and 3: the four corners
    // ------------------------------------------------------------------
    logic signed [dbd_pkg::Q_W-1:0] x1, y1, x2, y2;

    dbd_corner u_left (
        .aclk(aclk), .ctl(corner_ctl), .center(p1_cx_reg), .size(p1_w_reg),
        .pad(x_pad_reg), .far_edge(1'b0), .inv_scale(inv_scale_reg), .corner(x1)
    );
    dbd_corner u_top (
        .aclk(aclk), .ctl(corner_ctl), .center(p1_cy_reg), .size(p1_h_reg),
        .pad(y_pad_reg), .far_edge(1'b0), .inv_scale(inv_scale_reg), .corner(y1)
    );
    dbd_corner u_right (
        .aclk(aclk), .ctl(corner_ctl), .center(p1_cx_reg), .size(p1_w_reg),
        .pad(x_pad_reg), .far_edge(1'b1), .inv_scale(inv_scale_reg), .corner(x2)
    );
    dbd_corner u_bottom (
        .aclk(aclk), .ctl(corner_ctl), .center(p1_cy_reg), .size(p1_h_reg),
        .pad(y_pad_reg), .far_edge(1'b1), .inv_scale(inv_scale_reg), .corner(y2)
    );

    // ------------------------------------------------------------------
    // Output stage: clamp and register
    // ------------------------------------------------------------------
    localparam logic signed [dbd_pkg::Q_W-1:0] LO_MAX =
        dbd_pkg::Q_W'((1 << dbd_pkg::EDGE_LO_W) - 1);
    localparam logic signed [dbd_pkg::Q_W-1:0] HI_MIN =
        -dbd_pkg::Q_W'(1 << (dbd_pkg::EDGE_HI_W - 1));

    logic [dbd_pkg::EDGE_LO_W-1:0]        left_c, top_c;
    logic signed [dbd_pkg::EDGE_HI_W-1:0] right_c, bottom_c;
    logic signed [dbd_pkg::Q_W-1:0]       w_lim, h_lim;

    always_comb begin
        w_lim = $signed({{(dbd_pkg::Q_W-dbd_pkg::IMG_W){1'b0}}, img_w_reg});
        h_lim = $signed({{(dbd_pkg::Q_W-dbd_pkg::IMG_W){1'b0}}, img_h_reg});

        // left / top: clamp at 0, saturate high
        if (x1 < 0)           left_c = '0;
        else if (x1 > LO_MAX) left_c = LO_MAX[dbd_pkg::EDGE_LO_W-1:0];
        else                  left_c = x1[dbd_pkg::EDGE_LO_W-1:0];

        if (y1 < 0)           top_c = '0;
        else if (y1 > LO_MAX) top_c = LO_MAX[dbd_pkg::EDGE_LO_W-1:0];
        else                  top_c = y1[dbd_pkg::EDGE_LO_W-1:0];

        // right / bottom: saturate low, limit to image size
        if (x2 < HI_MIN)     right_c = HI_MIN[dbd_pkg::EDGE_HI_W-1:0];
        else if (x2 > w_lim) right_c = w_lim[dbd_pkg::EDGE_HI_W-1:0];
        else                 right_c = x2[dbd_pkg::EDGE_HI_W-1:0];

        if (y2 < HI_MIN)     bottom_c = HI_MIN[dbd_pkg::EDGE_HI_W-1:0];
        else if (y2 > h_lim) bottom_c = h_lim[dbd_pkg::EDGE_HI_W-1:0];
        else                 bottom_c = y2[dbd_pkg::EDGE_HI_W-1:0];
    end

    logic [dbd_pkg::CLASS_W-1:0]          label_reg;
    logic [dbd_pkg::SCORE_W-1:0]          confidence_reg;
    logic [dbd_pkg::EDGE_LO_W-1:0]        left_reg, top_reg;
    logic signed [dbd_pkg::EDGE_HI_W-1:0] right_reg, bottom_reg;

    always_ff @(posedge aclk) begin
        if (p3_adv) begin
            label_reg      <= p3_class_reg;
            confidence_reg <= p3_score_reg;
            left_reg       <= left_c;
            top_reg        <= top_c;
            right_reg      <= right_c;
            bottom_reg     <= bottom_c;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_label      = label_reg;
    assign m_confidence = confidence_reg;
    assign m_left       = left_reg;
    assign m_top        = top_reg;
    assign m_right      = right_reg;
    assign m_bottom     = bottom_reg;

endmodule

`default_nettype wire

// ===== sv/dbd_corner.sv =====
// One box corner: letterbox offset, reciprocal scale multiply, truncate toward zero.
`default_nettype none

module dbd_corner (
    input  wire logic                            aclk,
    input  wire dbd_pkg::stage_ctl_t             ctl,
    input  wire logic [dbd_pkg::COORD_W-1:0]     center,
    input  wire logic [dbd_pkg::COORD_W-1:0]     size,
    input  wire logic [dbd_pkg::PAD_W-1:0]       pad,
    input  wire logic                            far_edge,
    input  wire logic [dbd_pkg::SCALE_W-1:0]     inv_scale,
    output logic signed [dbd_pkg::Q_W-1:0]       corner
);

    logic signed [dbd_pkg::NUM_W-1:0] twice_c;
    logic signed [dbd_pkg::NUM_W-1:0] size_s;
    logic signed [dbd_pkg::NUM_W-1:0] pad_s;
    logic signed [dbd_pkg::NUM_W-1:0] num;
    logic        [dbd_pkg::NUM_W-1:0] num_abs;

    logic [dbd_pkg::MAG_W-1:0]  mag_reg;
    logic                       neg_reg;
    logic [dbd_pkg::PROD_W-1:0] prod_reg;
    logic                       neg_p_reg;
    logic [dbd_pkg::QMAG_W-1:0] q_mag;

    // 2*center +/- size - pad*32, all in 1/32 network pixel
    always_comb begin
        twice_c = $signed({{(dbd_pkg::NUM_W-dbd_pkg::COORD_W-1){1'b0}}, center, 1'b0});
        size_s  = $signed({{(dbd_pkg::NUM_W-dbd_pkg::COORD_W){1'b0}}, size});
        pad_s   = $signed({{(dbd_pkg::NUM_W-dbd_pkg::PAD_W-dbd_pkg::PAD_SHIFT){1'b0}},
                           pad, {dbd_pkg::PAD_SHIFT{1'b0}}});
        num     = far_edge ? (twice_c + size_s - pad_s) : (twice_c - size_s - pad_s);
        num_abs = num[dbd_pkg::NUM_W-1] ? dbd_pkg::NUM_W'(-num) : dbd_pkg::NUM_W'(num);
    end

    always_ff @(posedge aclk) begin
        if (ctl.num_load) begin
            mag_reg <= num_abs[dbd_pkg::MAG_W-1:0];
            neg_reg <= num[dbd_pkg::NUM_W-1];
        end
        if (ctl.prod_load) begin
            prod_reg  <= dbd_pkg::PROD_W'(mag_reg) * dbd_pkg::PROD_W'(inv_scale);
            neg_p_reg <= neg_reg;
        end
    end

    // truncate magnitude, then restore sign
    always_comb begin
        q_mag  = prod_reg[dbd_pkg::PROD_W-1:dbd_pkg::SCALE_SHIFT];
        corner = neg_p_reg ? -$signed({2'b00, q_mag}) : $signed({2'b00, q_mag});
    end

endmodule

`default_nettype wire

// ===== sv/dbd_checker.sv =====
// Port-level checker for the detection box decoder, bound to the top level.
`default_nettype none

module dbd_checker (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    input  wire logic                                s_ready,
    input  wire logic                                m_valid,
    input  wire logic                                m_ready,
    input  wire logic [dbd_pkg::CLASS_W-1:0]         m_label,
    input  wire logic [dbd_pkg::SCORE_W-1:0]         m_confidence,
    input  wire logic [dbd_pkg::EDGE_LO_W-1:0]       m_left,
    input  wire logic [dbd_pkg::EDGE_LO_W-1:0]       m_top,
    input  wire logic signed [dbd_pkg::EDGE_HI_W-1:0] m_right,
    input  wire logic signed [dbd_pkg::EDGE_HI_W-1:0] m_bottom
);

    // reset empties the output register
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid set after reset");

    // pipeline is empty after reset, so the input side is open
    a_ready_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> s_ready)
        else $error("s_ready low right after reset");

    // a waiting score transaction is not withdrawn
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("s_valid dropped before transaction");

    // a stalled detection stays presented
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("m_valid dropped before transaction");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_label) && $stable(m_confidence)
            && $stable(m_left) && $stable(m_top) && $stable(m_right) && $stable(m_bottom))
        else $error("detection payload changed while stalled");

endmodule

bind detection_box_decoder dbd_checker u_dbd_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_label(m_label),
    .m_confidence(m_confidence), .m_left(m_left), .m_top(m_top),
    .m_right(m_right), .m_bottom(m_bottom)
);

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the detection box decoder: directed corner cases plus random boxes.
`timescale 1ns / 1ps

module tb;

    // Limits and pacing
    localparam int CYCLE_LIMIT    = 400000;  // several times the slowest legal run
    localparam int DRAIN_CYCLES   = 6;       // pipeline drain after the last expected detection, with margin
    localparam int MAX_GAP        = 16;      // longest sender idle stretch per transaction
    localparam int ROUND_SCORES   = 75;      // score transactions per random register setting

    // Indexes past the register map; writes there must be dropped.
    localparam logic [dbd_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [dbd_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    typedef struct packed {
        logic [dbd_pkg::COORD_W-1:0] cx;
        logic [dbd_pkg::COORD_W-1:0] cy;
        logic [dbd_pkg::COORD_W-1:0] w;
        logic [dbd_pkg::COORD_W-1:0] h;
        logic [dbd_pkg::SCORE_W-1:0] score;
        logic                        last;
    } score_item_t;

    typedef struct packed {
        logic [dbd_pkg::CLASS_W-1:0]          label;
        logic [dbd_pkg::SCORE_W-1:0]          confidence;
        logic [dbd_pkg::EDGE_LO_W-1:0]        left;
        logic [dbd_pkg::EDGE_LO_W-1:0]        top;
        logic signed [dbd_pkg::EDGE_HI_W-1:0] right;
        logic signed [dbd_pkg::EDGE_HI_W-1:0] bottom;
    } detection_t;

    // DUT ports; the inputs are driven to known values from time zero
    logic                                 aclk = 1'b0;
    logic                                 aresetn = 1'b0;
    logic                                 cfg_wr_en = 1'b0;
    logic [dbd_pkg::CFG_IDX_W-1:0]        cfg_index = '0;
    logic [dbd_pkg::CFG_DATA_W-1:0]       cfg_wdata = '0;
    logic                                 s_valid = 1'b0;
    logic                                 s_ready;
    logic [dbd_pkg::COORD_W-1:0]          s_center_x = '0;
    logic [dbd_pkg::COORD_W-1:0]          s_center_y = '0;
    logic [dbd_pkg::COORD_W-1:0]          s_box_width = '0;
    logic [dbd_pkg::COORD_W-1:0]          s_box_height = '0;
    logic [dbd_pkg::SCORE_W-1:0]          s_class_score = '0;
    logic                                 s_last_score = 1'b0;
    logic                                 m_valid;
    logic                                 m_ready = 1'b0;
    logic [dbd_pkg::CLASS_W-1:0]          m_label;
    logic [dbd_pkg::SCORE_W-1:0]          m_confidence;
    logic [dbd_pkg::EDGE_LO_W-1:0]        m_left;
    logic [dbd_pkg::EDGE_LO_W-1:0]        m_top;
    logic signed [dbd_pkg::EDGE_HI_W-1:0] m_right;
    logic signed [dbd_pkg::EDGE_HI_W-1:0] m_bottom;

    // Shadow copy of the configuration registers (reset defaults)
    logic [dbd_pkg::SCORE_W-1:0] thr_reg       = dbd_pkg::THRESH_RST;
    logic [dbd_pkg::PAD_W-1:0]   xpad_reg      = '0;
    logic [dbd_pkg::PAD_W-1:0]   ypad_reg      = '0;
    logic [dbd_pkg::SCALE_W-1:0] inv_scale_reg = dbd_pkg::SCALE_RST;
    logic [dbd_pkg::IMG_W-1:0]   img_w_reg     = dbd_pkg::IMG_RST;
    logic [dbd_pkg::IMG_W-1:0]   img_h_reg     = dbd_pkg::IMG_RST;

    // Arg-max and latched box of the box in progress
    logic [dbd_pkg::SCORE_W-1:0] top_score = '0;
    logic [dbd_pkg::CLASS_W-1:0] top_class = '0;
    int                          class_slot = 0;
    logic [dbd_pkg::COORD_W-1:0] box_cx = '0;
    logic [dbd_pkg::COORD_W-1:0] box_cy = '0;
    logic [dbd_pkg::COORD_W-1:0] box_w = '0;
    logic [dbd_pkg::COORD_W-1:0] box_h = '0;
    logic                        box_in_progress = 1'b0;

    detection_t pending_detections[$];

    // Pacing knobs, percent per cycle
    int sender_idle_pct    = 6;
    int receiver_stall_pct = 84;

    // Bookkeeping
    int scores_sent      = 0;
    int detections_seen  = 0;
    int settings_written = 0;
    int mismatches       = 0;
    int cycle_count      = 0;

    detection_box_decoder uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_center_x    (s_center_x),
        .s_center_y    (s_center_y),
        .s_box_width   (s_box_width),
        .s_box_height  (s_box_height),
        .s_class_score (s_class_score),
        .s_last_score  (s_last_score),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_label       (m_label),
        .m_confidence  (m_confidence),
        .m_left        (m_left),
        .m_top         (m_top),
        .m_right       (m_right),
        .m_bottom      (m_bottom)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Undo the letterbox scale: (num * inverse scale) >> 21, rounding toward zero.
    function automatic longint unletterbox(longint num);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag * longint'(inv_scale_reg)) >> dbd_pkg::SCALE_SHIFT;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint limit(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Advance the arg-max by one score; on the closing score, queue the detection
    // if the best score clears the threshold.
    function automatic void decode_score(score_item_t it);
        detection_t det;
        longint     px;
        longint     py;
        longint     x1;
        longint     y1;
        longint     x2;
        longint     y2;
        if (!box_in_progress) begin
            // first score of a box latches its geometry and restarts the arg-max
            box_cx     = it.cx;
            box_cy     = it.cy;
            box_w      = it.w;
            box_h      = it.h;
            top_score  = '0;
            top_class  = '0;
            class_slot = 0;
        end
        // strict compare: the earliest class keeps a tie
        if (it.score > top_score) begin
            top_score = it.score;
            top_class = class_slot[dbd_pkg::CLASS_W-1:0];
        end
        if (!it.last) begin
            box_in_progress = 1'b1;
            // class index sticks at the top class once the box runs long
            if (class_slot + 1 < dbd_pkg::MAX_CLASSES)
                class_slot++;
            return;
        end
        box_in_progress = 1'b0;
        class_slot = 0;
        if (top_score < thr_reg)
            return;

        // corners in 1/32 network pixel, padding scaled to match
        px = longint'(xpad_reg) << dbd_pkg::PAD_SHIFT;
        py = longint'(ypad_reg) << dbd_pkg::PAD_SHIFT;
        x1 = unletterbox(2 * longint'(box_cx) - longint'(box_w) - px);
        y1 = unletterbox(2 * longint'(box_cy) - longint'(box_h) - py);
        x2 = unletterbox(2 * longint'(box_cx) + longint'(box_w) - px);
        y2 = unletterbox(2 * longint'(box_cy) + longint'(box_h) - py);

        x1             = limit(x1, 0, 8191);
        y1             = limit(y1, 0, 8191);
        x2             = limit(x2, -8192, longint'(img_w_reg));
        y2             = limit(y2, -8192, longint'(img_h_reg));
        det.label      = top_class;
        det.confidence = top_score;
        det.left       = x1[dbd_pkg::EDGE_LO_W-1:0];
        det.top        = y1[dbd_pkg::EDGE_LO_W-1:0];
        det.right      = x2[dbd_pkg::EDGE_HI_W-1:0];
        det.bottom     = y2[dbd_pkg::EDGE_HI_W-1:0];
        pending_detections.insert(pending_detections.size(), det);
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Random ready on the detection side; the DUT sees what was driven last edge.
    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // One score transaction: optional idle gap, then hold valid until accepted.
    // Entered and left at a rising edge.
    task automatic send_score(input score_item_t it);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            gap++;
        end
        s_valid       <= 1'b1;
        s_center_x    <= it.cx;
        s_center_y    <= it.cy;
        s_box_width   <= it.w;
        s_box_height  <= it.h;
        s_class_score <= it.score;
        s_last_score  <= it.last;
        do @(posedge aclk); while (!s_ready);
        decode_score(it);
        scores_sent++;
    endtask

    function automatic score_item_t make_item(int cx, int cy, int w, int h, int score, bit last);
        score_item_t it;
        it.cx    = cx[dbd_pkg::COORD_W-1:0];
        it.cy    = cy[dbd_pkg::COORD_W-1:0];
        it.w     = w[dbd_pkg::COORD_W-1:0];
        it.h     = h[dbd_pkg::COORD_W-1:0];
        it.score = score[dbd_pkg::SCORE_W-1:0];
        it.last  = last;
        return it;
    endfunction

    // Stop sending and let every queued detection come back, then let the
    // pipeline run dry in case the last box produced nothing.
    task automatic wait_for_idle();
        s_valid <= 1'b0;
        while (pending_detections.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic write_register(input logic [dbd_pkg::CFG_IDX_W-1:0] index,
                                  input logic [dbd_pkg::CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        @(posedge aclk);
        case (index)
            dbd_pkg::REG_SCORE_THRESHOLD: thr_reg       = data[dbd_pkg::SCORE_W-1:0];
            dbd_pkg::REG_X_PADDING:       xpad_reg      = data[dbd_pkg::PAD_W-1:0];
            dbd_pkg::REG_Y_PADDING:       ypad_reg      = data[dbd_pkg::PAD_W-1:0];
            dbd_pkg::REG_INVERSE_SCALE:   inv_scale_reg = data[dbd_pkg::SCALE_W-1:0];
            dbd_pkg::REG_IMAGE_WIDTH:     img_w_reg     = data[dbd_pkg::IMG_W-1:0];
            dbd_pkg::REG_IMAGE_HEIGHT:    img_h_reg     = data[dbd_pkg::IMG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [dbd_pkg::CFG_DATA_W-1:0] thr, xpad, ypad, scale,
                                  input logic [dbd_pkg::CFG_DATA_W-1:0] img_w, img_h);
        wait_for_idle();
        write_register(dbd_pkg::REG_SCORE_THRESHOLD, thr);
        write_register(dbd_pkg::REG_X_PADDING, xpad);
        write_register(dbd_pkg::REG_Y_PADDING, ypad);
        write_register(dbd_pkg::REG_INVERSE_SCALE, scale);
        write_register(dbd_pkg::REG_IMAGE_WIDTH, img_w);
        write_register(dbd_pkg::REG_IMAGE_HEIGHT, img_h);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        settings_written++;
    endtask

    // Register value leaning toward the extremes, with some out-of-width junk
    // so the write masking gets exercised.
    function automatic logic [dbd_pkg::CFG_DATA_W-1:0] biased_setting(
            input logic [dbd_pkg::CFG_DATA_W-1:0] lowest, highest, input int typ_lo, typ_hi);
        int pick;
        pick = $urandom_range(99);
        if (pick < 8) return lowest;
        if (pick < 14) return highest;
        if (pick < 18) return dbd_pkg::CFG_DATA_W'($urandom);
        return dbd_pkg::CFG_DATA_W'($urandom_range(typ_hi, typ_lo));
    endfunction

    // One complete box with random length, geometry and score pattern.
    task automatic send_random_box();
        score_item_t                 it;
        int                          pick;
        int                          n;
        int                          mode;
        logic [dbd_pkg::COORD_W-1:0] cx;
        logic [dbd_pkg::COORD_W-1:0] cy;
        logic [dbd_pkg::COORD_W-1:0] bw;
        logic [dbd_pkg::COORD_W-1:0] bh;
        pick = $urandom_range(99);
        if (pick < 70)
            n = $urandom_range(8, 1);
        else if (pick < 95)
            n = $urandom_range(40, 9);
        else if (pick < 99)
            n = $urandom_range(120, 41);
        else
            n = $urandom_range(280, 250);   // may run past the class index ceiling
        mode = $urandom_range(2);
        if ($urandom_range(3) != 0) begin
            // plausible box inside a 640 px network frame
            cx = dbd_pkg::COORD_W'($urandom_range(10240));
            cy = dbd_pkg::COORD_W'($urandom_range(10240));
            bw = dbd_pkg::COORD_W'($urandom_range(4096));
            bh = dbd_pkg::COORD_W'($urandom_range(4096));
        end else begin
            cx = dbd_pkg::COORD_W'($urandom);
            cy = dbd_pkg::COORD_W'($urandom);
            bw = dbd_pkg::COORD_W'($urandom);
            bh = dbd_pkg::COORD_W'($urandom);
        end
        for (int i = 0; i < n; i++) begin
            // geometry on later scores is don't-care, so it gets noise
            it.cx = (i == 0) ? cx : dbd_pkg::COORD_W'($urandom);
            it.cy = (i == 0) ? cy : dbd_pkg::COORD_W'($urandom);
            it.w  = (i == 0) ? bw : dbd_pkg::COORD_W'($urandom);
            it.h  = (i == 0) ? bh : dbd_pkg::COORD_W'($urandom);
            case (mode)
                0: it.score = dbd_pkg::SCORE_W'($urandom);
                1: begin
                    // few distinct values, so ties are common
                    case ($urandom_range(3))
                        0: it.score = '0;
                        1: it.score = 16'd16384;
                        2: it.score = 16'd40000;
                        default: it.score = '1;
                    endcase
                end
                default: it.score = dbd_pkg::SCORE_W'($urandom_range(20000));
            endcase
            it.last = (i == n - 1);
            send_score(it);
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    function automatic void compare_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        detection_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_detections.size() == 0) begin
                $error("detection transaction with none expected: class %0d conf %0d",
                       m_label, m_confidence);
                mismatches++;
            end else begin
                want = pending_detections.pop_front();
                compare_field("label", want.label, m_label);
                compare_field("confidence", want.confidence, m_confidence);
                compare_field("left", want.left, m_left);
                compare_field("top", want.top, m_top);
                compare_field("right", want.right, m_right);
                compare_field("bottom", want.bottom, m_bottom);
            end
            detections_seen++;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d detections outstanding",
                     cycle_count, pending_detections.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset register values: threshold 0.25, unit scale, no padding, 640x640.
    task automatic test_reset_defaults();
        send_score(make_item(0, 0, 0, 0, 0, 1));                        // zero score, no output
        send_score(make_item(8000, 6000, 1600, 800, 16383, 1));         // just under threshold
        // exactly at threshold; left clamps at 0, bottom hits the image size
        send_score(make_item(0, 16383, 16383, 16383, 16384, 1));
        // tie between the first two classes: class 0 keeps it
        send_score(make_item(5000, 5000, 2000, 2000, 50000, 0));
        send_score(make_item(1, 2, 3, 4, 50000, 0));
        send_score(make_item(16383, 16383, 16383, 16383, 20000, 1));
        // best arrives later, equal score after it does not move it
        send_score(make_item(3200, 4800, 640, 960, 100, 0));
        send_score(make_item(0, 0, 0, 0, 65535, 0));
        send_score(make_item(0, 0, 0, 0, 65535, 1));
    endtask

    task automatic test_register_extremes();
        // threshold 0, zero scale, zero image size: a zero score emits, all corners 0
        apply_settings(0, 1023, 1023, 0, 0, 0);
        send_score(make_item(16383, 16383, 16383, 16383, 0, 1));
        // top threshold, largest scale: left/top saturate high
        apply_settings(65535, 0, 0, 24'hFFFFFF, 8191, 8191);
        send_score(make_item(16383, 16383, 0, 0, 65534, 1));
        send_score(make_item(16383, 16383, 0, 0, 65535, 1));
        // full padding, largest scale, 1x1 image: right/bottom saturate low
        apply_settings(0, 1023, 1023, 24'hFFFFFF, 1, 1);
        send_score(make_item(0, 0, 16383, 16383, 1, 1));
        // writes past the map are dropped; bits above a register's width are dropped
        wait_for_idle();
        write_register(REG_UNMAPPED_LO, 24'hFFFFFF);
        write_register(REG_UNMAPPED_HI, '0);
        write_register(dbd_pkg::REG_X_PADDING, 24'hFFFC05);
        write_register(dbd_pkg::REG_IMAGE_WIDTH, 24'hFFE280);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        send_score(make_item(4000, 4000, 640, 640, 30000, 1));
    endtask

    // A box longer than the class range: the index sticks at the top class.
    task automatic test_class_overflow();
        apply_settings(0, 0, 0, dbd_pkg::CFG_DATA_W'(dbd_pkg::SCALE_RST),
                       dbd_pkg::CFG_DATA_W'(dbd_pkg::IMG_RST),
                       dbd_pkg::CFG_DATA_W'(dbd_pkg::IMG_RST));
        for (int i = 0; i < dbd_pkg::MAX_CLASSES + 4; i++)
            send_score(make_item(2000, 3000, 400, 500, i + 1, i == dbd_pkg::MAX_CLASSES + 3));
        // the next box must restart at class 0
        send_score(make_item(100, 100, 50, 50, 7, 1));
    endtask

    // Random boxes under several register settings per pacing phase.
    task automatic test_random_boxes();
        int target;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 6;  receiver_stall_pct = 84; end
                1: begin sender_idle_pct = 84; receiver_stall_pct = 6;  end
                default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
            endcase
            for (int round = 0; round < 4; round++) begin
                apply_settings(biased_setting(0, 65535, 0, 40000),
                               biased_setting(0, 1023, 0, 200),
                               biased_setting(0, 1023, 0, 200),
                               biased_setting(0, 24'hFFFFFF, 16384, 262144),
                               biased_setting(0, 8191, 16, 4000),
                               biased_setting(0, 8191, 16, 4000));
                target = scores_sent + ROUND_SCORES;
                while (scores_sent < target)
                    send_random_box();
            end
        end
    endtask

    initial begin
        // reset held from time zero, released on an edge
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_register_extremes();
        test_class_overflow();
        test_random_boxes();

        wait_for_idle();
        repeat (10) @(posedge aclk);

        $display("ran %0d score transactions, checked %0d detections", scores_sent,
                 detections_seen);
        $display("across %0d register settings and three pacing phases", settings_written);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
